// ----- rtl/mer_pkg.sv -----
// Shared types, constants and command codes for the midpoint ellipse rasterizer.
package mer_pkg;

  localparam int COORD_BITS_DEF = 11;  // default coordinate and semi-axis width
  localparam int OUT_W          = 13;  // width of the mirrored output coordinates
  localparam int DW             = 48;  // decision variable width, two's complement

  localparam logic FUNC_START  = 1'b0;
  localparam logic FUNC_STEP   = 1'b1;
  localparam logic REGION_TOP  = 1'b0;
  localparam logic REGION_SIDE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_AA,
    ST_MUL_BB,
    ST_MUL_BAA,
    ST_MUL_ABB,
    ST_INIT,
    ST_STEP_B,
    ST_STEP_C,
    ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_AA,
    OP_MUL_BB,
    OP_MUL_BAA,
    OP_MUL_ABB,
    OP_INIT,
    OP_STEP_A,
    OP_STEP_B,
    OP_REGION2
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    logic    emit;        // load the output register this cycle
    logic    emit_valid;  // point is to be plotted
    logic    emit_last;   // final result of the ellipse
  } ctrl_cmd_t;

  typedef struct packed {
    logic axis_zero;  // a start item carries a zero semi-axis
    logic region;     // current region
    logic test_ok;    // region test passed on the last step
    logic out_free;   // output register can take a result
  } dp_status_t;

endpackage

// ----- rtl/mer_in_if.sv -----
// Input channel: start/step requests with semi-axes and center.
interface mer_in_if #(
  parameter int CW = mer_pkg::COORD_BITS_DEF
) ();
  logic          valid;
  logic          ready;
  logic          func;
  logic [CW-1:0] semi_x;
  logic [CW-1:0] semi_y;
  logic [CW-1:0] center_x;
  logic [CW-1:0] center_y;

  modport source (
    output valid, func, semi_x, semi_y, center_x, center_y,
    input  ready
  );
  modport sink (
    input  valid, func, semi_x, semi_y, center_x, center_y,
    output ready
  );
endinterface

// ----- rtl/mer_out_if.sv -----
// Output channel: four mirrored coordinates plus region and status flags.
interface mer_out_if ();
  logic                              valid;
  logic                              ready;
  logic signed [mer_pkg::OUT_W-1:0]  px_right;
  logic signed [mer_pkg::OUT_W-1:0]  px_left;
  logic signed [mer_pkg::OUT_W-1:0]  py_down;
  logic signed [mer_pkg::OUT_W-1:0]  py_up;
  logic                              region;
  logic                              valid_res;
  logic                              last;

  modport source (
    output valid, px_right, px_left, py_down, py_up, region, valid_res, last,
    input  ready
  );
  modport sink (
    input  valid, px_right, px_left, py_down, py_up, region, valid_res, last,
    output ready
  );
endinterface

// ----- rtl/mer_ctrl.sv -----
// Controller state machine: sequences setup multiplies, steps and result hand-off.
module mer_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_func,
  output logic                in_ready,
  output mer_pkg::ctrl_cmd_t  cmd,
  input  mer_pkg::dp_status_t status
);
  import mer_pkg::*;

  state_t state, state_next;
  logic   active, active_next;
  logic   flag_valid, flag_valid_next;
  logic   flag_last, flag_last_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      active     <= 1'b0;
      flag_valid <= 1'b0;
      flag_last  <= 1'b0;
    end else begin
      state      <= state_next;
      active     <= active_next;
      flag_valid <= flag_valid_next;
      flag_last  <= flag_last_next;
    end
  end

  // next state
  always_comb begin
    state_next      = state;
    active_next     = active;
    flag_valid_next = flag_valid;
    flag_last_next  = flag_last;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_func == FUNC_START) begin
            if (status.axis_zero) begin
              state_next      = ST_EMIT;
              active_next     = 1'b0;
              flag_valid_next = 1'b0;
              flag_last_next  = 1'b1;
            end else begin
              state_next = ST_MUL_AA;
            end
          end else if (active) begin
            state_next = ST_STEP_B;
          end else begin
            state_next      = ST_EMIT;
            flag_valid_next = 1'b0;
            flag_last_next  = 1'b1;
          end
        end
      end
      ST_MUL_AA:  state_next = ST_MUL_BB;
      ST_MUL_BB:  state_next = ST_MUL_BAA;
      ST_MUL_BAA: state_next = ST_MUL_ABB;
      ST_MUL_ABB: state_next = ST_INIT;
      ST_INIT: begin
        state_next      = ST_EMIT;
        active_next     = 1'b1;
        flag_valid_next = 1'b1;
        flag_last_next  = 1'b0;
      end
      ST_STEP_B:  state_next = ST_STEP_C;
      ST_STEP_C: begin
        state_next = ST_EMIT;
        if (status.test_ok || status.region == REGION_TOP) begin
          flag_valid_next = 1'b1;
          flag_last_next  = 1'b0;
        end else begin
          active_next     = 1'b0;
          flag_valid_next = 1'b0;
          flag_last_next  = 1'b1;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready       = (state == ST_IDLE);
    cmd.op         = OP_NONE;
    cmd.emit       = 1'b0;
    cmd.emit_valid = flag_valid;
    cmd.emit_last  = flag_last;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_func == FUNC_START) begin
            cmd.op = OP_LOAD;
          end else if (active) begin
            cmd.op = OP_STEP_A;
          end
        end
      end
      ST_MUL_AA:  cmd.op = OP_MUL_AA;
      ST_MUL_BB:  cmd.op = OP_MUL_BB;
      ST_MUL_BAA: cmd.op = OP_MUL_BAA;
      ST_MUL_ABB: cmd.op = OP_MUL_ABB;
      ST_INIT:    cmd.op = OP_INIT;
      ST_STEP_B:  cmd.op = OP_STEP_B;
      ST_STEP_C: begin
        if (!status.test_ok && status.region == REGION_TOP) begin
          cmd.op = OP_REGION2;
        end
      end
      ST_EMIT:    cmd.emit = status.out_free;
      default:    cmd.op = OP_NONE;
    endcase
  end

endmodule

// ----- rtl/mer_dp.sv -----
// Datapath: shared multiplier, incremental decision arithmetic, output register.
module mer_dp #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mer_pkg::ctrl_cmd_t                cmd,
  output mer_pkg::dp_status_t               status,
  input  logic [COORD_BITS-1:0]             semi_x,
  input  logic [COORD_BITS-1:0]             semi_y,
  input  logic [COORD_BITS-1:0]             center_x,
  input  logic [COORD_BITS-1:0]             center_y,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic signed [mer_pkg::OUT_W-1:0]  px_right,
  output logic signed [mer_pkg::OUT_W-1:0]  px_left,
  output logic signed [mer_pkg::OUT_W-1:0]  py_down,
  output logic signed [mer_pkg::OUT_W-1:0]  py_up,
  output logic                              region,
  output logic                              valid_res,
  output logic                              last
);
  import mer_pkg::*;

  localparam int KW = 2 * COORD_BITS;      // a*a, b*b
  localparam int PW = 3 * COORD_BITS;      // multiplier product
  localparam int TW = 3 * COORD_BITS + 2;  // running x*b*b and y*a*a
  localparam int XW = COORD_BITS + 2;      // point offsets
  localparam int EW = (XW > OUT_W) ? XW : OUT_W;

  logic [COORD_BITS-1:0] axis_a, axis_b, origin_x, origin_y;
  logic [KW-1:0]         aa, bb;
  logic [PW-1:0]         mul, abb;
  logic [COORD_BITS-1:0] mul_a;
  logic [KW-1:0]         mul_b;
  logic [DW-1:0]         decision, part, corr, sixaa, sixbb, d2init;
  logic [XW-1:0]         cur_x, cur_y;
  logic [TW-1:0]         tx, ty;
  logic                  region_r, test_ok;
  logic                  neg;
  logic [EW-1:0]         sum_xr, sum_xl, sum_yd, sum_yu;

  // multiplier operand select
  always_comb begin
    mul_a = axis_a;
    mul_b = KW'(axis_a);
    case (cmd.op)
      OP_MUL_BB: begin
        mul_a = axis_b;
        mul_b = KW'(axis_b);
      end
      OP_MUL_BAA: begin
        mul_a = axis_b;
        mul_b = aa;
      end
      OP_MUL_ABB: begin
        mul_a = axis_a;
        mul_b = bb;
      end
      default: begin
      end
    endcase
  end

  assign neg = decision[DW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      region_r <= REGION_TOP;
      test_ok  <= 1'b0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          axis_a   <= semi_x;
          axis_b   <= semi_y;
          origin_x <= center_x;
          origin_y <= center_y;
        end
        OP_MUL_AA: mul <= PW'(mul_a) * PW'(mul_b);
        OP_MUL_BB: begin
          aa  <= mul[KW-1:0];
          mul <= PW'(mul_a) * PW'(mul_b);
        end
        OP_MUL_BAA: begin
          bb  <= mul[KW-1:0];
          mul <= PW'(mul_a) * PW'(mul_b);
        end
        OP_MUL_ABB: begin
          ty  <= TW'(mul);
          mul <= PW'(mul_a) * PW'(mul_b);
        end
        OP_INIT: begin
          abb      <= mul;
          decision <= (DW'(ty) << 1) - DW'(aa) - (DW'(bb) << 1);
          d2init   <= (DW'(mul) << 1) - DW'(bb) - (DW'(aa) << 1);
          sixaa    <= (DW'(aa) << 2) + (DW'(aa) << 1);
          sixbb    <= (DW'(bb) << 2) + (DW'(bb) << 1);
          cur_x    <= '0;
          cur_y    <= XW'(axis_b);
          tx       <= '0;
          region_r <= REGION_TOP;
        end
        OP_STEP_A: begin
          if (region_r == REGION_TOP) begin
            part  <= decision - sixbb - (DW'(tx) << 2);
            corr  <= neg ? ((DW'(ty) << 2) - (DW'(aa) << 2)) : '0;
            cur_x <= cur_x + XW'(1);
            tx    <= tx + TW'(bb);
            if (neg) begin
              cur_y <= cur_y - XW'(1);
              ty    <= ty - TW'(aa);
            end
          end else begin
            part  <= decision - sixaa - (DW'(ty) << 2);
            corr  <= neg ? ((DW'(tx) << 2) - (DW'(bb) << 2)) : '0;
            cur_y <= cur_y + XW'(1);
            ty    <= ty + TW'(aa);
            if (neg) begin
              cur_x <= cur_x - XW'(1);
              tx    <= tx - TW'(bb);
            end
          end
        end
        OP_STEP_B: begin
          decision <= part + corr;
          test_ok  <= (region_r == REGION_TOP) ? (tx <= ty) : (ty <= tx);
        end
        OP_REGION2: begin
          region_r <= REGION_SIDE;
          cur_x    <= XW'(axis_a);
          cur_y    <= '0;
          tx       <= TW'(abb);
          ty       <= '0;
          decision <= d2init;
        end
        default: begin
        end
      endcase
    end
  end

  // mirrored coordinates, wrapped to the output width
  assign sum_xr = EW'(origin_x) + EW'(cur_x);
  assign sum_xl = EW'(origin_x) - EW'(cur_x);
  assign sum_yd = EW'(origin_y) + EW'(cur_y);
  assign sum_yu = EW'(origin_y) - EW'(cur_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      valid_res <= cmd.emit_valid;
      last      <= cmd.emit_last;
      if (cmd.emit_valid) begin
        px_right <= sum_xr[OUT_W-1:0];
        px_left  <= sum_xl[OUT_W-1:0];
        py_down  <= sum_yd[OUT_W-1:0];
        py_up    <= sum_yu[OUT_W-1:0];
        region   <= region_r;
      end else begin
        px_right <= '0;
        px_left  <= '0;
        py_down  <= '0;
        py_up    <= '0;
        region   <= REGION_TOP;
      end
    end
  end

  assign status.axis_zero = (semi_x == '0) || (semi_y == '0);
  assign status.region    = region_r;
  assign status.test_ok   = test_ok;
  assign status.out_free  = !out_valid || out_ready;

endmodule

// ----- rtl/midpoint_ellipse_raster_core.sv -----
// Top level of the midpoint ellipse rasterizer: controller, datapath and checks.
//
// One result per input transfer. A start transfer (func = 0) loads the semi-axes and
// center and returns the top point (x = 0, y = b); each step transfer (func = 1)
// returns the next point as four mirrored coordinates. Region one walks from the top,
// region two from the right end; the step on which region two's test fails returns an
// invalid result with last set and the block goes idle. A start with a zero semi-axis,
// or a step while idle, also returns an invalid result marked last. The block is busy
// from an input transfer until its result is loaded into the output register. A step
// splits the decision update over two adder stages with the region test in the second,
// makes the optional hand-over to region two in the state after them, and then loads
// the result register. A start first makes four passes through the one shared
// multiplier that forms a*a, b*b, b*a*a and a*b*b. After setup no multiplies are
// needed: x*b*b and y*a*a are carried as running sums. A finished result sits in the
// output register, so a new input is taken while it waits; the block only stalls if
// the next result is ready before the previous one has been taken.
module midpoint_ellipse_raster_core #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  mer_in_if.sink    in_ch,
  mer_out_if.source out_ch
);
  import mer_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencing: one item in flight, command per cycle to the datapath
  mer_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .status   (status)
  );

  // arithmetic, point state and output register
  mer_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .semi_x    (in_ch.semi_x),
    .semi_y    (in_ch.semi_y),
    .center_x  (in_ch.center_x),
    .center_y  (in_ch.center_y),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .px_right  (out_ch.px_right),
    .px_left   (out_ch.px_left),
    .py_down   (out_ch.py_down),
    .py_up     (out_ch.py_up),
    .region    (out_ch.region),
    .valid_res (out_ch.valid_res),
    .last      (out_ch.last)
  );

`ifndef SYNTHESIS
  // a plotted point never ends the ellipse
  a_valid_not_last: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !(out_ch.valid_res && out_ch.last))
    else $error("plotted point flagged last");

  // invalid results carry zero payload
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.valid_res) |->
      (out_ch.px_right == '0 && out_ch.px_left == '0 && out_ch.py_down == '0 &&
       out_ch.py_up == '0 && out_ch.region == REGION_TOP))
    else $error("invalid result with nonzero payload");

  // a result is only loaded when the output register is free
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_ch.valid || out_ch.ready))
    else $error("result overwrites a pending transfer");

  // a step starts only on an input transfer
  a_step_on_transfer: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_STEP_A) |-> (in_ch.valid && in_ch.ready && in_ch.func == FUNC_STEP))
    else $error("step issued without an input transfer");
`endif

endmodule
